// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the packet integrity checker.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a synchronous active-low reset as the disable condition.
`define PIC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pic_pkg.sv -----
// Shared constants and types of the packet integrity checker.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

  localparam int ByteW   = 8;
  localparam int WordW   = 32;
  localparam int SumW    = 30;
  localparam int CntW    = 32;
  localparam int CfgIdxW = 2;

  localparam int PackLenDef = 32;

  // Checksum modulus and its multiples that still fit a 32-bit word.
  localparam logic [WordW-1:0] Mod1 = 32'd1000000007;
  localparam logic [WordW-1:0] Mod2 = 32'd2000000014;
  localparam logic [WordW-1:0] Mod3 = 32'd3000000021;
  localparam logic [WordW-1:0] Mod4 = 32'd4000000028;

  typedef enum logic [CfgIdxW-1:0] {
    RegHdrFirst  = 2'd0,
    RegHdrSecond = 2'd1,
    RegHdrThird  = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/pic_byte_if.sv -----
// Input byte channel of the packet integrity checker.
// Depends on pic_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

interface pic_byte_if;
  import pic_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/pic_result_if.sv -----
// Result channel of the packet integrity checker, one request per pack.
// Depends on pic_pkg for the counter width.
`timescale 1ns / 1ps
`default_nettype none

interface pic_result_if;
  import pic_pkg::*;

  logic            valid;
  logic            ready;
  logic            pack_ok;
  logic [CntW-1:0] good_pack_total;
  logic [CntW-1:0] bad_pack_total;

  modport source (output valid, output pack_ok, output good_pack_total,
                  output bad_pack_total, input ready);
  modport sink   (input valid, input pack_ok, input good_pack_total,
                  input bad_pack_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/pic_cfg_if.sv -----
// Register write channel of the packet integrity checker.
// Depends on pic_pkg for the index and data widths.
`timescale 1ns / 1ps
`default_nettype none

interface pic_cfg_if;
  import pic_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] reg_index;
  logic [ByteW-1:0]   reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/packet_integrity_checker.sv -----
// Top level of the packet integrity checker: byte assembly, checksum and verdict.
// Depends on pic_pkg, the three channel interfaces and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The checker takes one byte per cycle from in_if and groups every PACK_LEN
// bytes into a pack of little-endian 32-bit words. All words but the last are
// summed modulo 1000000007; the last word is the sent checksum. On the last byte
// of a pack one request is registered for out_if: pack_ok is high when the checksum is
// nonzero, equals the computed sum, and the first byte of the pack matches one of
// the three header registers, and the wrapping good and bad totals follow it.
// The block accepts a byte in every cycle, and only the last byte of a pack
// waits, while an earlier result is still not taken on out_if. A completed
// word is reduced in one stage and added to the sum in the next, so the sum is
// settled before the last byte of the checksum word is taken. Header registers
// are written over cfg_if at any time and take effect on the pack whose last
// byte follows the write.
module packet_integrity_checker #(
  parameter int PACK_LEN = pic_pkg::PackLenDef
) (
  input  wire          clk,
  input  wire          rst_n,
  pic_byte_if.sink     in_if,
  pic_result_if.source out_if,
  pic_cfg_if.sink      cfg_if
);
  import pic_pkg::*;

  localparam int PosW = $clog2(PACK_LEN);
  localparam logic [PosW-1:0] LastPos = PosW'(PACK_LEN - 1);
  localparam logic [1:0] LastLane = 2'd3;

  // Header registers.
  logic [ByteW-1:0] hdr_first_r, hdr_second_r, hdr_third_r;

  // Byte assembly.
  logic [PosW-1:0]    pos_r;
  logic [3*ByteW-1:0] gather_r;
  logic [ByteW-1:0]   first_byte_r;

  // Checksum pipeline.
  logic             word_vld_r;
  logic [WordW-1:0] word_r;
  logic             red_vld_r;
  logic [SumW-1:0]  red_r;
  logic [SumW-1:0]  red_nxt;
  logic [SumW-1:0]  sum_r;
  logic [SumW-1:0]  sum_nxt;
  logic [SumW:0]    sum_wide;

  // Verdict and totals.
  logic            out_valid_r;
  logic            pack_ok_r;
  logic [CntW-1:0] good_r;
  logic [CntW-1:0] bad_r;

  logic             in_acc;
  logic             out_acc;
  logic             is_last;
  logic             fin_acc;
  logic [1:0]       lane;
  logic [WordW-1:0] cur_word;
  logic             hdr_hit;
  logic             pack_ok;
  logic [CntW-1:0]  cnt_total;
  logic [CntW-1:0]  cnt_step;

  assign lane     = pos_r[1:0];
  assign is_last  = (pos_r == LastPos);
  assign in_if.ready = !is_last || !out_valid_r || out_if.ready;
  assign in_acc   = in_if.valid && in_if.ready;
  assign fin_acc  = in_acc && is_last;
  assign out_acc  = out_valid_r && out_if.ready;
  assign cur_word = {in_if.byte_value, gather_r};

  assign hdr_hit = (first_byte_r == hdr_first_r) || (first_byte_r == hdr_second_r) ||
                   (first_byte_r == hdr_third_r);
  assign pack_ok = (cur_word != '0) && (cur_word == {2'b00, sum_r}) && hdr_hit;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= '0;
      hdr_second_r <= '0;
      hdr_third_r  <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.reg_index))
        RegHdrFirst:  hdr_first_r  <= cfg_if.reg_data;
        RegHdrSecond: hdr_second_r <= cfg_if.reg_data;
        RegHdrThird:  hdr_third_r  <= cfg_if.reg_data;
        default: ;
      endcase
    end
  end

  // Position counter and word assembly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      word_vld_r <= 1'b0;
    end else begin
      word_vld_r <= in_acc && (lane == LastLane) && !is_last;
      if (in_acc) begin
        pos_r <= is_last ? '0 : pos_r + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (pos_r == '0) begin
        first_byte_r <= in_if.byte_value;
      end
      if (lane == LastLane) begin
        word_r <= cur_word;
      end else begin
        gather_r[lane*ByteW +: ByteW] <= in_if.byte_value;
      end
    end
  end

  // Reduce the completed word below the modulus.
  always_comb begin
    priority if (word_r >= Mod4) begin
      red_nxt = SumW'(word_r - Mod4);
    end else if (word_r >= Mod3) begin
      red_nxt = SumW'(word_r - Mod3);
    end else if (word_r >= Mod2) begin
      red_nxt = SumW'(word_r - Mod2);
    end else if (word_r >= Mod1) begin
      red_nxt = SumW'(word_r - Mod1);
    end else begin
      red_nxt = SumW'(word_r);
    end
  end

  always_comb begin
    sum_wide = {1'b0, sum_r} + {1'b0, red_r};
    if (sum_wide >= (SumW+1)'(Mod1)) begin
      sum_nxt = SumW'(sum_wide - (SumW+1)'(Mod1));
    end else begin
      sum_nxt = sum_wide[SumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_vld_r <= 1'b0;
      sum_r     <= '0;
    end else begin
      red_vld_r <= word_vld_r;
      if (fin_acc) begin
        sum_r <= '0;
      end else if (red_vld_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_vld_r) begin
      red_r <= red_nxt;
    end
  end

  // Verdict, totals and output register. The totals only move when a new
  // result is loaded, so they drive the output directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      good_r      <= '0;
      bad_r       <= '0;
    end else begin
      if (fin_acc) begin
        out_valid_r <= 1'b1;
        if (pack_ok) begin
          good_r <= good_r + CntW'(1);
        end else begin
          bad_r <= bad_r + CntW'(1);
        end
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_acc) begin
      pack_ok_r <= pack_ok;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.pack_ok         = pack_ok_r;
  assign out_if.good_pack_total = good_r;
  assign out_if.bad_pack_total  = bad_r;

  assign cnt_total = good_r + bad_r;
  assign cnt_step  = cnt_total + CntW'(1);

  `PIC_ASSERT(a_sum_reduced, clk, rst_n, sum_r < Mod1[SumW-1:0], "running sum not reduced")
  `PIC_ASSERT(a_sum_settled, clk, rst_n, !(red_vld_r && fin_acc), "sum compared unsettled")
  `PIC_ASSERT(a_word_aligned, clk, rst_n, !word_vld_r || (lane == 2'd0), "word off boundary")
  `PIC_ASSERT_NEXT(a_cnt_step, clk, rst_n, fin_acc, cnt_total == $past(cnt_step), "count step")
  `PIC_ASSERT_NEXT(a_result_loaded, clk, rst_n, fin_acc, out_valid_r, "result not presented")

endmodule

`default_nettype wire
